// ===== sv/nats_pkg.sv =====
package nats_pkg;

    // Default sizes handed to the top level parameters
    localparam int TEAM_SLOTS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 4;
    localparam int MASK_W  = 16;
    localparam int TIME_W  = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // an item is taken this cycle
        logic issue;     // read the slot under the walk counter
        logic sweep;     // current walk is a sweep, not a select
        logic load_out;  // copy the best slot into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_issue;  // walk counter sits on the last slot
        logic pipe_busy;   // slot pipeline still holds reads
    } dp_stat_t;

endpackage

// ===== sv/nats_req_if.sv =====
interface nats_req_if #(
    parameter int COORD_BITS = nats_pkg::COORD_BITS_DEF
) ();
    import nats_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             command;
    logic [INDEX_W-1:0]           team_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         available;
    logic                         has_address;
    logic [MASK_W-1:0]            exclude_mask;

    modport source (
        output valid, command, team_index, pos_x, pos_y, available, has_address,
               exclude_mask,
        input  ready
    );

    modport sink (
        input  valid, command, team_index, pos_x, pos_y, available, has_address,
               exclude_mask,
        output ready
    );

endinterface

// ===== sv/nats_res_if.sv =====
interface nats_res_if #(
    parameter int COORD_BITS = nats_pkg::COORD_BITS_DEF
) ();
    import nats_pkg::*;

    localparam int DIST_BITS = 2 * COORD_BITS + 1;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [INDEX_W-1:0]   chosen_index;
    logic                 chosen_available;
    logic [DIST_BITS-1:0] distance_squared;

    modport source (
        output valid, found, chosen_index, chosen_available, distance_squared,
        input  ready
    );

    modport sink (
        input  valid, found, chosen_index, chosen_available, distance_squared,
        output ready
    );

endinterface

// ===== sv/nats_ctrl.sv =====
module nats_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [nats_pkg::CMD_W-1:0] in_command,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output nats_pkg::dp_cmd_t        cmd,
    input  nats_pkg::dp_stat_t       stat
);
    import nats_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       sweep_reg, sweep_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Sequencer: walk the slots, drain the pipeline, post the result
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = accept;
        cmd.sweep    = sweep_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_command inside {CMD_SELECT, CMD_SWEEP}))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.issue = 1'b1;
                if (stat.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    if (sweep_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Walk kind and output valid
    always_comb
    begin
        sweep_next = accept ? (in_command == CMD_SWEEP) : sweep_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sweep_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // A new result never overwrites one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // New items only enter with an empty slot pipeline
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !stat.pipe_busy)
        else $error("item accepted while pipeline busy");

    // A walk always ends in the drain state
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && stat.last_issue) |=> (state_reg == ST_DRAIN))
        else $error("walk did not move to drain");
`endif

endmodule

// ===== sv/nats_dp.sv =====
module nats_dp #(
    parameter int TEAM_SLOTS = nats_pkg::TEAM_SLOTS_DEF,
    parameter int COORD_BITS = nats_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nats_pkg::dp_cmd_t                cmd,
    output nats_pkg::dp_stat_t               stat,
    input  logic                             cfg_we,
    input  logic [nats_pkg::TIME_W-1:0]      cfg_wdata,
    input  logic [nats_pkg::CMD_W-1:0]       in_command,
    input  logic [nats_pkg::INDEX_W-1:0]     in_team_index,
    input  logic signed [COORD_BITS-1:0]     in_pos_x,
    input  logic signed [COORD_BITS-1:0]     in_pos_y,
    input  logic                             in_available,
    input  logic                             in_has_address,
    input  logic [nats_pkg::MASK_W-1:0]      in_exclude_mask,
    output logic                             found,
    output logic [nats_pkg::INDEX_W-1:0]     chosen_index,
    output logic                             chosen_available,
    output logic [2*COORD_BITS:0]            distance_squared
);
    import nats_pkg::*;

    localparam int IW = $clog2(TEAM_SLOTS);
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int SW = 2 * COORD_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         avail;
        logic                         addressed;
        logic [TIME_W-1:0]            last_seen;
    } slot_rec_t;

    // Slot store: one write port, one registered read port
    slot_rec_t slot_mem [TEAM_SLOTS];
    slot_rec_t rd_rec_reg;
    slot_rec_t wr_rec;
    logic      mem_we;
    logic [IW-1:0] wr_addr;

    logic [TEAM_SLOTS-1:0] valid_bits_reg, valid_bits_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [TIME_W-1:0]     timeout_reg, timeout_next;
    logic [IW-1:0]         cnt_reg, cnt_next;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic [MASK_W-1:0]            mask_reg;
    logic [TEAM_SLOTS-1:0]        excl_vec;

    // Pipeline stage registers
    logic          s1_valid_reg, s1_ok_reg;
    logic [IW-1:0] s1_idx_reg;
    logic          s2_valid_reg, s2_ok_reg, s2_av_reg;
    logic [IW-1:0] s2_idx_reg;
    logic [COORD_BITS-1:0] s2_dx_reg, s2_dy_reg;
    logic          s3_valid_reg, s3_ok_reg, s3_av_reg;
    logic [IW-1:0] s3_idx_reg;
    logic [SW-1:0] s3_sqx_reg, s3_sqy_reg;

    logic          best_have_reg, best_av_reg;
    logic [IW-1:0] best_idx_reg;
    logic [DW-1:0] best_d_reg;

    logic                   found_reg, chosen_av_reg;
    logic [INDEX_W-1:0]     chosen_idx_reg;
    logic [DW-1:0]          dist_reg;

    logic [TIME_W-1:0]      age;
    logic                   sweep_clear;
    logic signed [COORD_BITS:0] dxs, dys;
    logic [COORD_BITS:0]    dxa, dya;
    logic [SW-1:0]          sqx, sqy;
    logic [DW-1:0]          dsum;
    logic                   win;

    // Exclude bits exist for the first MASK_W slots only
    for (genvar g = 0; g < TEAM_SLOTS; g++)
    begin : g_excl
        if (g < MASK_W)
        begin : g_bit
            assign excl_vec[g] = mask_reg[g];
        end
        else
        begin : g_none
            assign excl_vec[g] = 1'b0;
        end
    end

    // Update write
    assign wr_addr         = IW'(in_team_index);
    assign mem_we          = cmd.accept && (in_command == CMD_UPDATE)
                             && (32'(in_team_index) < TEAM_SLOTS);
    assign wr_rec.x        = in_pos_x;
    assign wr_rec.y        = in_pos_y;
    assign wr_rec.avail    = in_available;
    assign wr_rec.addressed = in_has_address;
    assign wr_rec.last_seen = time_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= wr_rec;
        end
        rd_rec_reg <= slot_mem[cnt_reg];
    end

    // Stage 1: stale check for sweeps, coordinate differences for selects
    assign age         = time_reg - rd_rec_reg.last_seen;
    assign sweep_clear = s1_valid_reg && cmd.sweep && (age > timeout_reg);
    assign dxs = {rd_rec_reg.x[COORD_BITS-1], rd_rec_reg.x} - {qx_reg[COORD_BITS-1], qx_reg};
    assign dys = {rd_rec_reg.y[COORD_BITS-1], rd_rec_reg.y} - {qy_reg[COORD_BITS-1], qy_reg};
    assign dxa = dxs[COORD_BITS] ? (COORD_BITS+1)'(-dxs) : (COORD_BITS+1)'(dxs);
    assign dya = dys[COORD_BITS] ? (COORD_BITS+1)'(-dys) : (COORD_BITS+1)'(dys);

    // Stage 2: squares
    assign sqx = {{COORD_BITS{1'b0}}, s2_dx_reg} * {{COORD_BITS{1'b0}}, s2_dx_reg};
    assign sqy = {{COORD_BITS{1'b0}}, s2_dy_reg} * {{COORD_BITS{1'b0}}, s2_dy_reg};

    // Stage 3: distance and priority compare
    assign dsum = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};
    assign win  = !best_have_reg
                  || (s3_av_reg && !best_av_reg)
                  || ((s3_av_reg == best_av_reg) && (dsum < best_d_reg));

    // Control state next values
    always_comb
    begin
        valid_bits_next = valid_bits_reg;
        if (mem_we)
        begin
            valid_bits_next[wr_addr] = 1'b1;
        end
        if (sweep_clear)
        begin
            valid_bits_next[s1_idx_reg] = 1'b0;
        end

        time_next = time_reg;
        if (cmd.accept && (in_command == CMD_TICK))
        begin
            time_next = time_reg + 1'b1;
        end

        timeout_next = cfg_we ? cfg_wdata : timeout_reg;

        cnt_next = cnt_reg;
        if (cmd.accept)
        begin
            cnt_next = '0;
        end
        else if (cmd.issue && !stat.last_issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign stat.last_issue = (cnt_reg == IW'(TEAM_SLOTS - 1));
    assign stat.pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
            time_reg       <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            cnt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_have_reg  <= 1'b0;
        end
        else
        begin
            valid_bits_reg <= valid_bits_next;
            time_reg       <= time_next;
            timeout_reg    <= timeout_next;
            cnt_reg        <= cnt_next;
            s1_valid_reg   <= cmd.issue;
            s2_valid_reg   <= s1_valid_reg && !cmd.sweep;
            s3_valid_reg   <= s2_valid_reg;
            if (cmd.accept)
            begin
                best_have_reg <= 1'b0;
            end
            else if (s3_valid_reg && s3_ok_reg && win)
            begin
                best_have_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qx_reg   <= in_pos_x;
            qy_reg   <= in_pos_y;
            mask_reg <= in_exclude_mask;
        end

        s1_idx_reg <= cnt_reg;
        s1_ok_reg  <= valid_bits_reg[cnt_reg] && !excl_vec[cnt_reg];

        s2_idx_reg <= s1_idx_reg;
        s2_ok_reg  <= s1_ok_reg && rd_rec_reg.addressed;
        s2_av_reg  <= rd_rec_reg.avail;
        s2_dx_reg  <= dxa[COORD_BITS-1:0];
        s2_dy_reg  <= dya[COORD_BITS-1:0];

        s3_idx_reg <= s2_idx_reg;
        s3_ok_reg  <= s2_ok_reg;
        s3_av_reg  <= s2_av_reg;
        s3_sqx_reg <= sqx;
        s3_sqy_reg <= sqy;

        if (s3_valid_reg && s3_ok_reg && win)
        begin
            best_idx_reg <= s3_idx_reg;
            best_av_reg  <= s3_av_reg;
            best_d_reg   <= dsum;
        end

        if (cmd.load_out)
        begin
            found_reg      <= best_have_reg;
            chosen_idx_reg <= best_have_reg ? INDEX_W'(best_idx_reg) : '0;
            chosen_av_reg  <= best_have_reg && best_av_reg;
            dist_reg       <= best_have_reg ? best_d_reg : '0;
        end
    end

    assign found            = found_reg;
    assign chosen_index     = chosen_idx_reg;
    assign chosen_available = chosen_av_reg;
    assign distance_squared = dist_reg;

`ifndef ASSERT_OFF
    // Squares stage only holds what the difference stage passed on
    a_s3_follow: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> $past(s2_valid_reg))
        else $error("square stage valid without a source");

    // Sweeps never feed the distance stages
    a_sweep_nodist: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && cmd.sweep) |=> !s2_valid_reg)
        else $error("sweep read entered distance stage");

    // Update and sweep never touch the valid bits together
    a_valid_onewr: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && sweep_clear))
        else $error("update and sweep clear in one cycle");
`endif

endmodule

// ===== sv/nearest_available_team_selector.sv =====
// Update and tick items leave the sequencer idle; the next item can be taken the cycle after.
// Select: one slot store read per cycle through a shared difference/square/compare pipeline;
// the result loads once the pipeline has drained and the output register is free.
// Sweep: one stale check per slot read.
// Results sit in an output register; new items are taken while one waits.
// Reset (rst_n low, async) clears slot valid bits and the time counter, timeout back to 10.
module nearest_available_team_selector #(
    parameter int TEAM_SLOTS = nats_pkg::TEAM_SLOTS_DEF,
    parameter int COORD_BITS = nats_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [nats_pkg::TIME_W-1:0] cfg_wdata,
    nats_req_if.sink                    req,
    nats_res_if.source                  res
);
    import nats_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;
    logic     out_valid;

    assign req.ready = in_ready;
    assign res.valid = out_valid;

    // Sequencer
    nats_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (res.ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Slot store and distance pipeline
    nats_dp #(
        .TEAM_SLOTS (TEAM_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_command       (req.command),
        .in_team_index    (req.team_index),
        .in_pos_x         (req.pos_x),
        .in_pos_y         (req.pos_y),
        .in_available     (req.available),
        .in_has_address   (req.has_address),
        .in_exclude_mask  (req.exclude_mask),
        .found            (res.found),
        .chosen_index     (res.chosen_index),
        .chosen_available (res.chosen_available),
        .distance_squared (res.distance_squared)
    );

endmodule
